FILE: hdl/sha1_hash_engine_top_defines.svh
// Assertion macros shared by the SHA-1 hash engine RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef SHA1_HASH_ENGINE_TOP_DEFINES_SVH
`define SHA1_HASH_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA1HE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SHA1HE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define SHA1HE_ASSERT(lbl, prop, msg)
`define SHA1HE_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: hdl/sha1he_pkg.sv
// Types and constants of the SHA-1 hash engine.
// Used by the front queue, the compression core and the top level.
package sha1he_pkg;

  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } item_t;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [6:0] ROUND_LAST = 7'd79;

endpackage

FILE: hdl/sha1_hash_engine_top.sv
// Top level of the SHA-1 hash engine: stream ports, front queue and compression core.
// Depends on sha1he_pkg, sha1he_front and sha1he_core.
// The engine takes one message byte per request (tuser low) and a finish request (tuser high)
// that returns the 160-bit digest as five 32-bit words, H0 first, tlast on the fifth. A two-entry
// queue takes requests while the core works. The core stores one byte a cycle while it is idle
// and, each time 64 bytes are held, runs the serial round loop over the block. A finish writes
// the pad byte, zero bytes up to the length field and the eight length bytes up to the block end;
// when fewer than nine bytes are left, zero bytes, if any, close the first block and a second
// block holds the length. The round loop runs once or twice, the five digest words are handed
// out, and the engine then restarts from the initial values.
module sha1_hash_engine_top
  import sha1he_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic        m_axis_tlast_o
);

  item_t item;
  logic  item_valid, item_pop;

  sha1he_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_finish_i  (s_axis_tuser_i),
    .in_data_i    (s_axis_tdata_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  sha1he_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_word_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

FILE: hdl/sha1he_front.sv
// Front end of the SHA-1 hash engine: accepts input requests and queues them.
// Depends on sha1he_pkg for the queued item type.
module sha1he_front
  import sha1he_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_finish_i,
  input  logic [7:0] in_data_i,
  output logic       item_valid_o,
  output item_t      item_o,
  input  logic       item_pop_i
);

  item_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        push, pop;

  assign in_ready_o   = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{finish: in_finish_i, data: in_data_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

FILE: hdl/sha1he_core.sv
// Back end of the SHA-1 hash engine: block buffer, padding, 80 rounds, digest out.
// Depends on sha1he_pkg and the assertion macros in sha1_hash_engine_top_defines.svh.
`include "sha1_hash_engine_top_defines.svh"
module sha1he_core
  import sha1he_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_word_o,
  output logic        out_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_ROUND,
    ST_OUT
  } state_e;

  state_e       state_q;
  logic [5:0]   fill_q;
  logic [63:0]  bits_q;
  logic [6:0]   rnd_q;
  logic         pad_q, len_done_q;
  logic [2:0]   out_idx_q;
  logic [31:0]  h0_q, h1_q, h2_q, h3_q, h4_q;
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [511:0] sched_q;
  logic [63:0]  len_q;
  logic [159:0] dig_q;

  logic [31:0]  w_cur, w_new, f_val, k_val, tmp;
  logic         shift_byte, shift_word, load_dig;
  logic [7:0]   byte_val;
  logic [31:0]  h0_d, h1_d, h2_d, h3_d, h4_d;

  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;
  assign out_word_o = dig_q[159:128];
  assign out_last_o = out_valid_o && (out_idx_q == 3'd4);

  always_comb begin
    logic [31:0] x;
    w_cur = sched_q[511:480];
    x     = sched_q[95:64] ^ sched_q[255:224] ^ sched_q[447:416] ^ w_cur;
    w_new = {x[30:0], x[31]};
    if (rnd_q < 7'd20) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = K0;
    end else if (rnd_q < 7'd40) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K1;
    end else if (rnd_q < 7'd60) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = K2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K3;
    end
    tmp = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_cur;
    h0_d = h0_q + tmp;
    h1_d = h1_q + a_q;
    h2_d = h2_q + {b_q[1:0], b_q[31:2]};
    h3_d = h3_q + c_q;
    h4_d = h4_q + d_q;
  end

  always_comb begin
    shift_byte = 1'b0;
    byte_val   = 8'd0;
    case (state_q)
      ST_IDLE: begin
        shift_byte = item_valid_i;
        byte_val   = item_i.finish ? PAD_BYTE : item_i.data;
      end
      ST_PAD_ZERO: begin
        shift_byte = (fill_q != LEN_START);
      end
      ST_PAD_LEN: begin
        shift_byte = 1'b1;
        byte_val   = len_q[63:56];
      end
      default: begin
        shift_byte = 1'b0;
      end
    endcase
    shift_word = (state_q == ST_ROUND);
    load_dig   = (state_q == ST_ROUND) && (rnd_q == ROUND_LAST) && pad_q && len_done_q;
  end

  always_ff @(posedge clk_i) begin
    if (shift_byte) begin
      sched_q <= {sched_q[503:0], byte_val};
    end else if (shift_word) begin
      sched_q <= {sched_q[479:0], w_new};
    end
    if (state_q == ST_ROUND) begin
      a_q <= tmp;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end else begin
      a_q <= h0_q;
      b_q <= h1_q;
      c_q <= h2_q;
      d_q <= h3_q;
      e_q <= h4_q;
    end
    if (state_q == ST_IDLE && item_valid_i && item_i.finish) begin
      len_q <= bits_q;
    end else if (state_q == ST_PAD_LEN) begin
      len_q <= {len_q[55:0], 8'd0};
    end
    if (load_dig) begin
      dig_q <= {h0_d, h1_d, h2_d, h3_d, h4_d};
    end else if (out_valid_o && out_ready_i) begin
      dig_q <= {dig_q[127:0], 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= 6'd0;
      bits_q      <= 64'd0;
      rnd_q       <= 7'd0;
      pad_q       <= 1'b0;
      len_done_q  <= 1'b0;
      out_idx_q   <= 3'd0;
      out_valid_o <= 1'b0;
      h0_q        <= H0_INIT;
      h1_q        <= H1_INIT;
      h2_q        <= H2_INIT;
      h3_q        <= H3_INIT;
      h4_q        <= H4_INIT;
    end else begin
      if (shift_byte) begin
        fill_q <= fill_q + 6'd1;
      end
      case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            if (item_i.finish) begin
              pad_q <= 1'b1;
              state_q <= (fill_q == FILL_LAST) ? ST_ROUND : ST_PAD_ZERO;
            end else begin
              bits_q <= bits_q + 64'd8;
              if (fill_q == FILL_LAST) begin
                state_q <= ST_ROUND;
              end
            end
          end
        end
        ST_PAD_ZERO: begin
          if (fill_q == LEN_START) begin
            state_q <= ST_PAD_LEN;
          end else if (fill_q == FILL_LAST) begin
            state_q <= ST_ROUND;
          end
        end
        ST_PAD_LEN: begin
          if (fill_q == FILL_LAST) begin
            len_done_q <= 1'b1;
            state_q    <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (rnd_q == ROUND_LAST) begin
            rnd_q <= 7'd0;
            if (load_dig) begin
              h0_q        <= H0_INIT;
              h1_q        <= H1_INIT;
              h2_q        <= H2_INIT;
              h3_q        <= H3_INIT;
              h4_q        <= H4_INIT;
              bits_q      <= 64'd0;
              pad_q       <= 1'b0;
              len_done_q  <= 1'b0;
              out_idx_q   <= 3'd0;
              out_valid_o <= 1'b1;
              state_q     <= ST_OUT;
            end else begin
              h0_q    <= h0_d;
              h1_q    <= h1_d;
              h2_q    <= h2_d;
              h3_q    <= h3_d;
              h4_q    <= h4_d;
              state_q <= pad_q ? ST_PAD_ZERO : ST_IDLE;
            end
          end else begin
            rnd_q <= rnd_q + 7'd1;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            if (out_idx_q == 3'd4) begin
              out_valid_o <= 1'b0;
              state_q     <= ST_IDLE;
            end else begin
              out_idx_q <= out_idx_q + 3'd1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `SHA1HE_ASSERT(a_out_only_in_out, out_valid_o == (state_q == ST_OUT), "Output valid outside the digest state.")
  `SHA1HE_ASSERT(a_round_range, (state_q != ST_ROUND) || (rnd_q <= ROUND_LAST), "Round counter past the last round.")
  `SHA1HE_ASSERT(a_out_block_empty, !out_valid_o || (fill_q == 6'd0), "Block buffer not empty while the digest drains.")
  `SHA1HE_ASSERT(a_len_after_pad, !len_done_q || pad_q, "Length written outside a finish sequence.")
  `SHA1HE_ASSERT_NEXT(a_last_ends, out_last_o && out_ready_i, !out_valid_o, "Digest continues after the last word.")

endmodule

FILE: bench/tb.sv
// Self-checking testbench for sha1_hash_engine_top: byte requests and finish requests in,
// five digest words out, compared against a SHA-1 predictor built into the bench.
// Depends on sha1he_pkg and the engine RTL only.
module tb;
  import sha1he_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [31:0] word_t;

  typedef struct {
    word_t word;
    logic  last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  word_t        hash_chain [5];
  logic [7:0]   msg_block [64];
  logic [5:0]   fill_pos;
  logic [63:0]  msg_bits;
  digest_beat_t pending_digest [$];

  bit          idle_en = 1'b1;
  bit          sink_hold = 1'b0;
  int unsigned sink_hold_cycles = 0;
  int unsigned sink_idle_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;

  sha1_hash_engine_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic word_t rotl(input word_t v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void reset_hash_state();
    hash_chain[0] = H0_INIT;
    hash_chain[1] = H1_INIT;
    hash_chain[2] = H2_INIT;
    hash_chain[3] = H3_INIT;
    hash_chain[4] = H4_INIT;
    fill_pos = '0;
    msg_bits = '0;
  endfunction

  function automatic void compress_block();
    word_t w [16];
    word_t a, b, c, d, e, f, k, tmp, nw;
    for (int t = 0; t < 16; t++) begin
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    end
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        nw = w[t];
      end else begin
        nw = rotl(w[(t+13)%16] ^ w[(t+8)%16] ^ w[(t+2)%16] ^ w[t%16], 1);
        w[t%16] = nw;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      tmp = rotl(a, 5) + f + e + k + nw;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = tmp;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    msg_block[fill_pos] = b;
    msg_bits += 64'd8;
    fill_pos += 6'd1;
    if (fill_pos == 6'd0) compress_block();
  endfunction

  function automatic void finish_digest();
    logic [63:0]  len;
    int           pos;
    digest_beat_t beat;
    len = msg_bits;
    pos = int'(fill_pos);
    msg_block[pos] = PAD_BYTE;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) msg_block[56+i] = len[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 5; i++) begin
      beat.word = hash_chain[i];
      beat.last = (i == 4);
      pending_digest.push_back(beat);
    end
    reset_hash_state();
  endfunction

  task automatic send_request(input bit fin, input logic [7:0] b);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    requests_sent++;
    if (fin) finish_digest();
    else absorb_byte(b);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_request(1'b0, 8'($urandom_range(0, 255)));
    send_request(1'b1, 8'($urandom_range(0, 255)));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_digest.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected digest word %h last %b", m_axis_tdata_o, m_axis_tlast_o);
        end
        mismatch_count++;
      end else begin
        if (pending_digest[0].word !== m_axis_tdata_o ||
            pending_digest[0].last !== m_axis_tlast_o) begin
          if (mismatch_count < 10) begin
            $display("digest mismatch: expected %h last %b, got %h last %b",
                     pending_digest[0].word, pending_digest[0].last,
                     m_axis_tdata_o, m_axis_tlast_o);
          end
          mismatch_count++;
        end
        void'(pending_digest.pop_front());
      end
    end
    if (sink_hold) begin
      m_axis_tready_i <= 1'b0;
    end else if (sink_idle_left != 0) begin
      m_axis_tready_i <= 1'b0;
      sink_idle_left--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready_i <= 1'b0;
      sink_idle_left = $urandom_range(0, 3);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (sink_hold_cycles != 0) begin
        sink_hold = 1'b1;
        repeat (sink_hold_cycles) @(posedge clk_i);
        sink_hold = 1'b0;
        sink_hold_cycles = 0;
      end
    end
  end

  task automatic test_empty_message();
    send_request(1'b1, 8'hFF);
  endtask

  task automatic test_known_vector();
    send_request(1'b0, 8'h61);
    send_request(1'b0, 8'h62);
    send_request(1'b0, 8'h63);
    send_request(1'b1, 8'h00);
  endtask

  task automatic test_byte_extremes();
    send_request(1'b0, 8'h00);
    send_request(1'b0, 8'hFF);
    send_request(1'b0, 8'h80);
    send_request(1'b0, 8'h7F);
    send_request(1'b1, 8'h55);
    send_request(1'b0, 8'hFF);
    send_request(1'b0, 8'hFF);
    send_request(1'b1, 8'hAA);
    send_request(1'b1, 8'h00);
    send_request(1'b1, 8'hFF);
  endtask

  task automatic test_output_stall();
    sink_hold_cycles = 400;
    @(posedge clk_i);
    send_message(3);
    send_message(2);
    send_message(6);
    send_message(0);
  endtask

  task automatic test_random_messages();
    int edge_lens [3] = '{55, 56, 63};
    int target;
    target = int'(requests_sent) + 180;
    foreach (edge_lens[i]) send_message(edge_lens[i]);
    while (int'(requests_sent) < target) begin
      case ($urandom_range(0, 3))
        0: send_message($urandom_range(0, 9));
        default: send_message($urandom_range(0, 20));
      endcase
    end
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    send_message(64);
    send_message(0);
    send_message(0);
    send_message(5);
  endtask

  initial begin
    reset_hash_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_message();
    test_known_vector();
    test_byte_extremes();
    test_output_stall();
    test_random_messages();
    test_back_to_back();
    s_axis_tvalid_i <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
